@@ rtl/magnetometer_average_hard_iron_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef MAGNETOMETER_AVERAGE_HARD_IRON_MACROS_SVH
`define MAGNETOMETER_AVERAGE_HARD_IRON_MACROS_SVH

// same-cycle implication, checked outside reset
`define MHI_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MHI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mhi_pkg.sv @@
`default_nettype none

package mhi_pkg;

  // sample and result widths
  localparam int SAMPLE_W  = 13;
  localparam int FIELD_W   = 14;
  localparam int NUM_AXES  = 3;

  // averaging window
  localparam int AVG_DEPTH = 10;
  localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W     = SAMPLE_W + $clog2(AVG_DEPTH);

  // divide by window depth as multiply by rounded-up reciprocal
  localparam int RECIP_SH  = SUM_W + $clog2(AVG_DEPTH);
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** RECIP_SH) + AVG_DEPTH - 1) / AVG_DEPTH);

  // item kinds on the request side
  typedef enum logic [1:0] {
    MODE_MEASURE   = 2'd0,
    MODE_CAL_BEGIN = 2'd1,
    MODE_CAL_POINT = 2'd2,
    MODE_CAL_END   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // pipeline load strobes from the top to each lane
  typedef struct packed {
    logic accept;
    logic s2_load;
  } pipe_ctrl_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // power-up calibration values per axis
  function automatic sample_t max_rst(input axis_e axis);
    sample_t r;
    case (axis)
      AXIS_X:  r = SAMPLE_W'(454);
      AXIS_Y:  r = SAMPLE_W'(744);
      AXIS_Z:  r = SAMPLE_W'(452);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic sample_t min_rst(input axis_e axis);
    sample_t r;
    case (axis)
      AXIS_X:  r = SAMPLE_W'(-718);
      AXIS_Y:  r = SAMPLE_W'(-503);
      AXIS_Z:  r = SAMPLE_W'(-704);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic sample_t off_rst(input axis_e axis);
    sample_t r;
    case (axis)
      AXIS_X:  r = SAMPLE_W'(-132);
      AXIS_Y:  r = SAMPLE_W'(120);
      AXIS_Z:  r = SAMPLE_W'(-126);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mhi_div.sv @@
`default_nettype none

module mhi_div (
  input  wire logic                                clk_i,
  input  wire logic                                load_i,
  input  wire logic signed [mhi_pkg::SUM_W-1:0]    sum_i,
  output logic signed [mhi_pkg::SAMPLE_W:0]        quot_o
);
  import mhi_pkg::*;

  logic [SUM_W-1:0]    mag;
  logic [PROD_W-1:0]   prod_d, prod_q;
  logic                neg_q;
  logic [SAMPLE_W-1:0] quot_mag;

  // magnitude times reciprocal
  assign mag    = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
  assign prod_d = PROD_W'(mag) * PROD_W'(RECIP);

  // product register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
      neg_q  <= sum_i[SUM_W-1];
    end
  end

  // quotient truncated toward zero, sign restored
  assign quot_mag = prod_q[RECIP_SH +: SAMPLE_W];
  assign quot_o   = neg_q ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});

endmodule

`default_nettype wire

@@ rtl/mhi_lane.sv @@
`default_nettype none

module mhi_lane (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mhi_pkg::axis_e                    axis_i,
  input  wire mhi_pkg::pipe_ctrl_t               ctrl_i,
  input  wire mhi_pkg::mode_e                    mode_i,
  input  wire logic [mhi_pkg::SLOT_W-1:0]        slot_i,
  input  wire mhi_pkg::sample_t                  sample_i,
  output logic signed [mhi_pkg::FIELD_W-1:0]     field_o
);
  import mhi_pkg::*;

  sample_t                   ring_q [AVG_DEPTH];
  logic signed [SUM_W-1:0]   sum_d, sum_q;
  sample_t                   max_d, max_q, min_d, min_q, off_d, off_q;
  logic signed [SAMPLE_W:0]  mid_sum, mid_adj;
  logic signed [SUM_W-1:0]   s1_sum_q;
  sample_t                   s1_off_q, s2_off_q;
  logic signed [SAMPLE_W:0]  quot;

  // offset midpoint, truncated toward zero
  assign mid_sum = {max_q[SAMPLE_W-1], max_q} + {min_q[SAMPLE_W-1], min_q};
  assign mid_adj = mid_sum + {{SAMPLE_W{1'b0}}, mid_sum[SAMPLE_W] & mid_sum[0]};

  // state update for the item being accepted
  always_comb begin
    sum_d = sum_q;
    max_d = max_q;
    min_d = min_q;
    off_d = off_q;
    case (mode_i)
      MODE_MEASURE: begin
        sum_d = sum_q + SUM_W'(sample_i) - SUM_W'(ring_q[slot_i]);
      end
      MODE_CAL_BEGIN: begin
        max_d = sample_i;
        min_d = sample_i;
        off_d = '0;
      end
      MODE_CAL_POINT: begin
        if (sample_i > max_q) max_d = sample_i;
        if (sample_i < min_q) min_d = sample_i;
      end
      MODE_CAL_END: begin
        off_d = mid_adj[SAMPLE_W:1];
      end
      default: begin
        sum_d = sum_q;
      end
    endcase
  end

  // ring, running sum and calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AVG_DEPTH; i++) ring_q[i] <= '0;
      sum_q <= '0;
      max_q <= max_rst(axis_i);
      min_q <= min_rst(axis_i);
      off_q <= off_rst(axis_i);
    end else if (ctrl_i.accept) begin
      if (mode_i == MODE_MEASURE) ring_q[slot_i] <= sample_i;
      sum_q <= sum_d;
      max_q <= max_d;
      min_q <= min_d;
      off_q <= off_d;
    end
  end

  // snapshot of updated sum and offset, and the offset passed on to stage two
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      s1_sum_q <= sum_d;
      s1_off_q <= off_d;
    end
    if (ctrl_i.s2_load) begin
      s2_off_q <= s1_off_q;
    end
  end

  mhi_div u_div (
    .clk_i  (clk_i),
    .load_i (ctrl_i.s2_load),
    .sum_i  (s1_sum_q),
    .quot_o (quot)
  );

  // average minus hard-iron offset
  assign field_o = FIELD_W'(quot) - FIELD_W'(s2_off_q);

endmodule

`default_nettype wire

@@ rtl/magnetometer_average_hard_iron.sv @@
// channel  | dir | tdata (low bit up)                          | tuser
// s_axis   | in  | raw_x[12:0] raw_y[25:13] raw_z[38:26], pad  | mode[1:0]
// m_axis   | out | field_x[13:0] field_y[27:14] field_z[41:28] | none
//
// one item per cycle sustained while the output is not stalled; each request gives one result
// three stages: state update and sum snapshot, reciprocal multiply, output register
// a stalled output fills the stages behind it before s_axis_tready_o drops
// reset clears the rings, the running sums and the write slot and loads the
// power-up calibration; there is no clearing pass
`default_nettype none

module magnetometer_average_hard_iron (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [39:0]  s_axis_tdata_i,   // raw_x, raw_y, raw_z, zero pad
  input  wire logic [1:0]   s_axis_tuser_i,   // mode
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [47:0]       m_axis_tdata_o    // field_x, field_y, field_z, zero pad
);
  import mhi_pkg::*;

  `include "magnetometer_average_hard_iron_macros.svh"

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVG_DEPTH - 1);

  logic                      s1_v_q, s2_v_q, out_v_q;
  logic                      out_free, s2_free, s2_move, s1_move, accept;
  logic [SLOT_W-1:0]         slot_d, slot_q;
  mode_e                     mode;
  pipe_ctrl_t                ctrl;
  sample_t                   sample   [NUM_AXES];
  logic signed [FIELD_W-1:0] field    [NUM_AXES];
  logic signed [FIELD_W-1:0] field_q  [NUM_AXES];

  // elastic pipeline moves
  assign out_free        = !out_v_q || m_axis_tready_i;
  assign s2_move         = s2_v_q && out_free;
  assign s2_free         = !s2_v_q || out_free;
  assign s1_move         = s1_v_q && s2_free;
  assign s_axis_tready_o = !s1_v_q || s2_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign mode         = mode_e'(s_axis_tuser_i);
  assign ctrl.accept  = accept;
  assign ctrl.s2_load = s1_move;

  // ring write slot
  always_comb begin
    slot_d = slot_q;
    if (accept && mode == MODE_MEASURE) begin
      slot_d = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
      if (s_axis_tready_o) s1_v_q  <= s_axis_tvalid_i;
      if (s2_free)         s2_v_q  <= s1_v_q;
      if (out_free)        out_v_q <= s2_v_q;
    end
  end

  // one lane per axis
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    assign sample[g] = s_axis_tdata_i[g*SAMPLE_W +: SAMPLE_W];

    mhi_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .axis_i   (axis_e'(g)),
      .ctrl_i   (ctrl),
      .mode_i   (mode),
      .slot_i   (slot_q),
      .sample_i (sample[g]),
      .field_o  (field[g])
    );
  end

  // merge lane results into the output register
  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      for (int a = 0; a < NUM_AXES; a++) field_q[a] <= field[a];
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {6'b0, field_q[2], field_q[1], field_q[0]};

  `MHI_ASSERT_NOW(a_slot_range, clk_i, rst_ni, 1'b1, slot_q <= SLOT_LAST,
    "write slot past window depth")
  `MHI_ASSERT_NEXT(a_slot_step, clk_i, rst_ni, accept && mode == MODE_MEASURE,
    slot_q == (($past(slot_q) == SLOT_LAST) ? '0 : $past(slot_q) + 1'b1),
    "write slot did not advance on measure request")
  `MHI_ASSERT_NOW(a_no_bubble_stall, clk_i, rst_ni, !s_axis_tready_o,
    s1_v_q && s2_v_q && out_v_q, "request side stalled with a free stage")
  `MHI_ASSERT_NEXT(a_result_lands, clk_i, rst_ni, s2_move, out_v_q,
    "multiply stage moved but no result appeared")

endmodule

`default_nettype wire
